// ----- hdl/for_pkg.sv -----
// Shared types and constants of the frame output reorder block.
package for_pkg;

   localparam int SRC_W = 4;
   localparam int CNT_W = 8;
   localparam int HINT_W = 4;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DATA_W = 4;

   localparam logic [SRC_W-1:0] FRAME_SOURCE = 4'd8;

   localparam logic [1:0] OP_LOAD  = 2'd0;
   localparam logic [1:0] OP_SHOW  = 2'd1;
   localparam logic [1:0] OP_DRAIN = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_HINT_BITS = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PASS      = 2'd1;

   typedef enum logic [1:0] {
      MODE_PRE   = 2'd0,
      MODE_HIT   = 2'd1,
      MODE_DRAIN = 2'd2
   } mode_type;

   // search token that walks the row of slot cells
   typedef struct packed {
      logic             valid;
      logic             found;
      logic [SRC_W-1:0] idx;
      logic [CNT_W-1:0] cpoc;
   } token_type;

   // broadcast from the sequencer to every cell
   typedef struct packed {
      logic              load;
      logic [2:0]        load_idx;
      logic              load_valid;
      logic              load_pending;
      logic [CNT_W-1:0]  load_count;
      logic              clear_used;
      logic              mark;
      logic [SRC_W-1:0]  mark_idx;
      mode_type          mode;
      logic [CNT_W-1:0]  last_count;
      logic [HINT_W-1:0] hint_bits;
   } ctl_type;

endpackage

// ----- hdl/for_cell.sv -----
// One reference slot: its marks, its count and one stage of the search chain.
module for_cell
   import for_pkg::*;
#(
   parameter int IDX = 0
) (
   input  logic      clock,
   input  logic      reset,
   input  ctl_type   ctl,
   input  token_type prev_tok,
   output token_type next_tok
);

   logic             valid_ff, valid_in;
   logic             pending_ff, pending_in;
   logic             used_ff, used_in;
   logic [CNT_W-1:0] count_ff, count_in;
   token_type        tok_ff, tok_in;

   logic             elig;
   logic             take;
   logic signed [8:0] d_last;
   logic signed [8:0] d_cand;

   // wrapping signed difference over the configured number of hint bits
   function automatic logic signed [8:0] hint_diff(logic [CNT_W-1:0] a, logic [CNT_W-1:0] b,
                                                   logic [HINT_W-1:0] bits);
      logic [HINT_W-1:0] n;
      logic [8:0]        full;
      logic [7:0]        d;
      logic [8:0]        r;
      n = (bits > 4'd8) ? 4'd8 : bits;
      full = 9'd1 << n;
      // for 8 bits the low byte of full is zero, so the mask wraps to all ones
      d = (a - b) & (full[7:0] - 8'd1);
      if (n == 4'd0)
         r = 9'd0;
      else if ((9'(d) & (full >> 1)) != 9'd0)
         r = 9'(d) - full;
      else
         r = 9'(d);
      return signed'(r);
   endfunction

   always_comb begin
      elig = valid_ff & pending_ff & ~used_ff;
      d_last = hint_diff(count_ff, ctl.last_count, ctl.hint_bits);
      d_cand = hint_diff(count_ff, prev_tok.cpoc, ctl.hint_bits);
      unique case (ctl.mode)
         MODE_PRE: begin
            take = elig && (d_last > 9'sd0) && (d_cand < 9'sd0);
         end
         MODE_HIT: begin
            take = elig && (d_last == 9'sd1) && !prev_tok.found;
         end
         MODE_DRAIN: begin
            take = elig && (d_last > 9'sd0) && (!prev_tok.found || (d_cand < 9'sd0));
         end
         default: begin
            take = 1'b0;
         end
      endcase

      tok_in = prev_tok;
      if (take) begin
         tok_in.found = 1'b1;
         tok_in.idx = SRC_W'(IDX);
         tok_in.cpoc = count_ff;
      end

      valid_in = valid_ff;
      pending_in = pending_ff;
      count_in = count_ff;
      if (ctl.load && (32'(ctl.load_idx) == IDX)) begin
         valid_in = ctl.load_valid;
         pending_in = ctl.load_pending;
         count_in = ctl.load_count;
      end

      used_in = used_ff;
      if (ctl.clear_used)
         used_in = 1'b0;
      else if (ctl.mark && (32'(ctl.mark_idx) == IDX))
         used_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         pending_ff <= 1'b0;
         used_ff <= 1'b0;
         tok_ff.valid <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         pending_ff <= pending_in;
         used_ff <= used_in;
         tok_ff.valid <= tok_in.valid;
      end
      count_ff <= count_in;
      tok_ff.found <= tok_in.found;
      tok_ff.idx <= tok_in.idx;
      tok_ff.cpoc <= tok_in.cpoc;
   end

   assign next_tok = tok_ff;

endmodule

// ----- hdl/frame_output_reorder.sv -----
// Top level: item sequencer, result register and the row of slot cells.
//
//   channel   ports                           handshake
//   request   start, busy, req_*              taken when start && !busy
//   result    rsp_valid, rsp_*                one-cycle strobe, no backpressure
//   config    csr_valid, csr_ready, csr_*     taken when csr_valid && csr_ready
//
// One search round injects a token at slot 0 and passes it through each cell
// register to the end of the cell row; the row sets the pace. A load needs no
// search; a show with k earlier or following slots walks the row k+2 times, a
// drain emitting k slots k+1 times; a pass-through show needs no search. Each
// result is registered out in the cycle after it is known to be last or not.
// Synchronous active-high reset clears marks and last count; config gets defaults.
module frame_output_reorder
   import for_pkg::*;
#(
   parameter int SLOT_COUNT = 8
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  logic [1:0]            req_opcode,
   input  logic [2:0]            req_slot_index,
   input  logic                  req_slot_present,
   input  logic                  req_already_shown,
   input  logic                  req_can_show_later,
   input  logic [CNT_W-1:0]      req_frame_count,
   output logic                  rsp_valid,
   output logic [SRC_W-1:0]      rsp_emitted_source,
   output logic [CNT_W-1:0]      rsp_emitted_count,
   output logic                  rsp_last_of_run,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_SCAN = 2'b10
   } state_type;

   state_type         state_ff, state_in;
   mode_type          mode_ff, mode_in;
   logic [CNT_W-1:0]  frame_ff, frame_in;
   logic [CNT_W-1:0]  last_ff, last_in;
   logic              inject_ff, inject_in;
   logic              held_valid_ff, held_valid_in;
   logic [SRC_W-1:0]  held_src_ff, held_src_in;
   logic [CNT_W-1:0]  held_cnt_ff, held_cnt_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [SRC_W-1:0]  rsp_src_ff, rsp_src_in;
   logic [CNT_W-1:0]  rsp_cnt_ff, rsp_cnt_in;
   logic              rsp_last_ff, rsp_last_in;
   logic [HINT_W-1:0] hint_bits_ff, hint_bits_in;
   logic              pass_ff, pass_in;

   logic              accept;
   ctl_type           ctl;
   token_type         chain [SLOT_COUNT+1];
   token_type         tail;
   logic [SLOT_COUNT-1:0] chain_valid;

   logic              emit_do;
   logic              emit_slot;
   logic [SRC_W-1:0]  emit_src;
   logic [CNT_W-1:0]  emit_cnt;
   logic              finish;

   assign accept = start && (state_ff == ST_IDLE);
   assign busy = (state_ff != ST_IDLE);
   assign csr_ready = 1'b1;

   assign chain[0] = '{valid: inject_ff, found: 1'b0, idx: '0, cpoc: frame_ff};
   assign tail = chain[SLOT_COUNT];

   for (genvar i = 0; i < SLOT_COUNT; i++) begin : g_cell
      for_cell #(.IDX(i)) u_cell (
         .clock    (clock),
         .reset    (reset),
         .ctl      (ctl),
         .prev_tok (chain[i]),
         .next_tok (chain[i+1])
      );
      assign chain_valid[i] = chain[i+1].valid;
   end

   always_comb begin
      state_in = state_ff;
      mode_in = mode_ff;
      frame_in = frame_ff;
      last_in = last_ff;
      inject_in = 1'b0;
      held_valid_in = held_valid_ff;
      held_src_in = held_src_ff;
      held_cnt_in = held_cnt_ff;
      rsp_valid_in = 1'b0;
      rsp_src_in = rsp_src_ff;
      rsp_cnt_in = rsp_cnt_ff;
      rsp_last_in = rsp_last_ff;
      hint_bits_in = hint_bits_ff;
      pass_in = pass_ff;

      emit_do = 1'b0;
      emit_slot = 1'b0;
      emit_src = tail.idx;
      emit_cnt = tail.cpoc;
      finish = 1'b0;

      ctl.load = accept && (req_opcode == OP_LOAD);
      ctl.load_idx = req_slot_index;
      ctl.load_valid = req_slot_present;
      ctl.load_pending = req_slot_present && !req_already_shown && req_can_show_later;
      ctl.load_count = req_frame_count;
      ctl.clear_used = 1'b0;
      ctl.mark = 1'b0;
      ctl.mark_idx = tail.idx;
      ctl.mode = mode_ff;
      ctl.last_count = last_ff;
      ctl.hint_bits = hint_bits_ff;

      if (csr_valid) begin
         unique case (csr_index)
            CSR_HINT_BITS: hint_bits_in = csr_wdata;
            CSR_PASS:      pass_in = csr_wdata[0];
            default: ;
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               unique case (req_opcode)
                  OP_SHOW: begin
                     frame_in = req_frame_count;
                     if (pass_ff) begin
                        rsp_valid_in = 1'b1;
                        rsp_src_in = FRAME_SOURCE;
                        rsp_cnt_in = req_frame_count;
                        rsp_last_in = 1'b1;
                        last_in = req_frame_count;
                     end else begin
                        ctl.clear_used = 1'b1;
                        mode_in = MODE_PRE;
                        inject_in = 1'b1;
                        state_in = ST_SCAN;
                     end
                  end
                  OP_DRAIN: begin
                     ctl.clear_used = 1'b1;
                     mode_in = MODE_DRAIN;
                     inject_in = 1'b1;
                     state_in = ST_SCAN;
                  end
                  default: ;
               endcase
            end
         end
         ST_SCAN: begin
            if (tail.valid) begin
               if (tail.found) begin
                  emit_do = 1'b1;
                  emit_slot = 1'b1;
                  inject_in = 1'b1;
               end else if (mode_ff == MODE_PRE) begin
                  // no earlier slot left: the frame itself goes out next
                  emit_do = 1'b1;
                  emit_src = FRAME_SOURCE;
                  emit_cnt = frame_ff;
                  mode_in = MODE_HIT;
                  inject_in = 1'b1;
               end else begin
                  finish = 1'b1;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // a held result goes out once it is known whether another follows
      if (emit_do) begin
         if (held_valid_ff) begin
            rsp_valid_in = 1'b1;
            rsp_src_in = held_src_ff;
            rsp_cnt_in = held_cnt_ff;
            rsp_last_in = 1'b0;
         end
         held_valid_in = 1'b1;
         held_src_in = emit_src;
         held_cnt_in = emit_cnt;
         last_in = emit_cnt;
         ctl.mark = emit_slot;
      end
      if (finish) begin
         if (held_valid_ff) begin
            rsp_valid_in = 1'b1;
            rsp_src_in = held_src_ff;
            rsp_cnt_in = held_cnt_ff;
            rsp_last_in = 1'b1;
         end
         held_valid_in = 1'b0;
         state_in = ST_IDLE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         mode_ff <= MODE_PRE;
         last_ff <= '0;
         inject_ff <= 1'b0;
         held_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         hint_bits_ff <= 4'd7;
         pass_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         mode_ff <= mode_in;
         last_ff <= last_in;
         inject_ff <= inject_in;
         held_valid_ff <= held_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         hint_bits_ff <= hint_bits_in;
         pass_ff <= pass_in;
      end
   end

   always_ff @(posedge clock) begin
      frame_ff <= frame_in;
      held_src_ff <= held_src_in;
      held_cnt_ff <= held_cnt_in;
      rsp_src_ff <= rsp_src_in;
      rsp_cnt_ff <= rsp_cnt_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_emitted_source = rsp_src_ff;
   assign rsp_emitted_count = rsp_cnt_ff;
   assign rsp_last_of_run = rsp_last_ff;

`ifndef SYNTHESIS
   a_one_token: assert property (@(posedge clock) disable iff (reset)
      $onehot0(chain_valid))
      else $error("more than one search token in the cell row");

   a_tail_in_scan: assert property (@(posedge clock) disable iff (reset)
      tail.valid |-> (state_ff == ST_SCAN))
      else $error("search token arrived outside a scan");

   a_held_in_scan: assert property (@(posedge clock) disable iff (reset)
      held_valid_ff |-> (state_ff == ST_SCAN))
      else $error("held result while idle");

   a_more_follows: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_last_of_run) |-> busy)
      else $error("non-final result but the item has finished");
`endif

endmodule

// ----- tb/tb_frame_output_reorder.sv -----
// Testbench for frame_output_reorder: random and directed items, scoreboard check.
module tb_frame_output_reorder;
   import for_pkg::*;

   localparam int SLOTS = 8;
   localparam logic [1:0] OP_UNUSED = 2'd3;
   // covers a full show item: at most ten rounds through the cell row, plus margin
   localparam int SETTLE_CYCLES = 10 * (SLOTS + 1) + 20;
   localparam int QUIET_LIMIT = 3000;
   localparam int PHASES = 7;
   localparam int ITEMS_PER_PHASE = 38;

   typedef struct packed {
      logic [SRC_W-1:0] source;
      logic [CNT_W-1:0] count;
      logic             last;
   } emission_type;

   // predicts display order and holds the emissions still to come
   class display_order_board;
      logic [HINT_W-1:0] hint_bits = 4'd7;
      logic              pass_mode = 1'b0;
      logic              slot_valid [SLOTS];
      logic              slot_pending [SLOTS];
      logic [CNT_W-1:0]  slot_count [SLOTS];
      logic [CNT_W-1:0]  last_count = '0;
      emission_type      due [$];
      int                errors = 0;
      int                checked = 0;

      function new();
         foreach (slot_valid[n]) begin
            slot_valid[n] = 1'b0;
            slot_pending[n] = 1'b0;
            slot_count[n] = '0;
         end
      endfunction

      function int order_gap(int a, int b);
         int width, span, d;
         width = (hint_bits > 8) ? 8 : int'(hint_bits);
         if (width == 0) return 0;
         span = 1 << width;
         d = (a - b) & (span - 1);
         return (d & (span >> 1)) ? d - span : d;
      endfunction

      function void push(logic [SRC_W-1:0] src, logic [CNT_W-1:0] cnt);
         emission_type e;
         e.source = src;
         e.count = cnt;
         e.last = 1'b0;
         due.push_back(e);
         last_count = cnt;
      endfunction

      function void note_item(logic [1:0] op, logic [2:0] idx, logic present,
                              logic shown, logic later, logic [CNT_W-1:0] cnt);
         int n, cand, first;
         logic [CNT_W-1:0] cpoc;
         logic [SLOTS-1:0] used;
         emission_type e;
         used = '0;
         first = due.size();
         case (op)
            OP_LOAD: begin
               slot_valid[idx] = present;
               slot_pending[idx] = present && !shown && later;
               slot_count[idx] = cnt;
            end
            OP_SHOW: begin
               // earlier hidden pictures first, nearest to the last output wins
               while (!pass_mode) begin
                  cand = -1;
                  cpoc = cnt;
                  for (n = 0; n < SLOTS; n++)
                     if (!used[n] && slot_valid[n] && slot_pending[n] &&
                         order_gap(int'(slot_count[n]), int'(last_count)) > 0 &&
                         order_gap(int'(slot_count[n]), int'(cpoc)) < 0) begin
                        cand = n;
                        cpoc = slot_count[n];
                     end
                  if (cand < 0) break;
                  push(cand[SRC_W-1:0], slot_count[cand]);
                  used[cand] = 1'b1;
               end
               push(FRAME_SOURCE, cnt);
               // then any run of direct successors
               while (!pass_mode) begin
                  cand = -1;
                  for (n = SLOTS - 1; n >= 0; n--)
                     if (!used[n] && slot_valid[n] && slot_pending[n] &&
                         order_gap(int'(slot_count[n]), int'(last_count)) == 1)
                        cand = n;
                  if (cand < 0) break;
                  push(cand[SRC_W-1:0], slot_count[cand]);
                  used[cand] = 1'b1;
               end
            end
            OP_DRAIN: begin
               while (1) begin
                  cand = -1;
                  cpoc = '0;
                  for (n = 0; n < SLOTS; n++)
                     if (!used[n] && slot_valid[n] && slot_pending[n] &&
                         order_gap(int'(slot_count[n]), int'(last_count)) > 0 &&
                         (cand < 0 || order_gap(int'(slot_count[n]), int'(cpoc)) < 0)) begin
                        cand = n;
                        cpoc = slot_count[n];
                     end
                  if (cand < 0) break;
                  push(cand[SRC_W-1:0], slot_count[cand]);
                  used[cand] = 1'b1;
               end
            end
            default: ;
         endcase
         if (due.size() > first) begin
            e = due[due.size() - 1];
            e.last = 1'b1;
            due[due.size() - 1] = e;
         end
      endfunction

      task report(string what);
         errors++;
         $display("ERROR: %s", what);
      endtask

      task check_emission(logic [SRC_W-1:0] src, logic [CNT_W-1:0] cnt, logic last);
         emission_type e;
         if (due.size() == 0) begin
            report($sformatf("unexpected result src=%0d count=%0d last=%0d",
                             src, cnt, last));
            return;
         end
         e = due.pop_front();
         checked++;
         if (src !== e.source || cnt !== e.count || last !== e.last)
            report($sformatf("result %0d: got src=%0d count=%0d last=%0d, want %0d/%0d/%0d",
                             checked, src, cnt, last, e.source, e.count, e.last));
      endtask
   endclass

   logic                  clock;
   logic                  reset;
   logic                  start;
   logic                  busy;
   logic [1:0]            req_opcode;
   logic [2:0]            req_slot_index;
   logic                  req_slot_present;
   logic                  req_already_shown;
   logic                  req_can_show_later;
   logic [CNT_W-1:0]      req_frame_count;
   logic                  rsp_valid;
   logic [SRC_W-1:0]      rsp_emitted_source;
   logic [CNT_W-1:0]      rsp_emitted_count;
   logic                  rsp_last_of_run;
   logic                  csr_valid;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   display_order_board board = new();
   int  quiet_cycles = 0;
   int  op_seen [4] = '{0, 0, 0, 0};
   int  settings_done = 0;
   bit  no_idle = 0;
   logic [CNT_W-1:0] hint_cursor;

   frame_output_reorder #(.SLOT_COUNT(SLOTS)) i_dut (.*);

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid)
         board.check_emission(rsp_emitted_source, rsp_emitted_count, rsp_last_of_run);
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid || (csr_valid && csr_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
   end

   initial begin
      wait (quiet_cycles >= QUIET_LIMIT);
      $display("ERROR: no handshake for %0d cycles", QUIET_LIMIT);
      $display("frame_output_reorder test failed");
      $finish;
   end

   function automatic int pick_gap();
      int r;
      if (no_idle) return 0;
      r = $urandom_range(99);
      if (r < 50) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // start stays high across back-to-back items; this task lowers it only for a gap
   task automatic send_item(logic [1:0] op, logic [2:0] idx, logic present,
                            logic shown, logic later, logic [CNT_W-1:0] cnt);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start <= 1'b1;
      req_opcode <= op;
      req_slot_index <= idx;
      req_slot_present <= present;
      req_already_shown <= shown;
      req_can_show_later <= later;
      req_frame_count <= cnt;
      do @(posedge clock); while (busy);
      board.note_item(op, idx, present, shown, later, cnt);
      op_seen[op]++;
   endtask

   task automatic load(logic [2:0] idx, logic present, logic shown, logic later,
                       logic [CNT_W-1:0] cnt);
      send_item(OP_LOAD, idx, present, shown, later, cnt);
   endtask

   task automatic show(logic [CNT_W-1:0] cnt);
      send_item(OP_SHOW, 3'($urandom_range(7)), 1'($urandom_range(1)),
                1'($urandom_range(1)), 1'($urandom_range(1)), cnt);
   endtask

   task automatic drain();
      send_item(OP_DRAIN, 3'($urandom_range(7)), 1'($urandom_range(1)),
                1'($urandom_range(1)), 1'($urandom_range(1)), CNT_W'($urandom_range(255)));
   endtask

   task automatic wait_idle();
      start <= 1'b0;
      while (board.due.size() != 0) @(posedge clock);
      // loads leave nothing to wait on, so let any search finish
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         csr_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      if (idx == CSR_HINT_BITS) board.hint_bits = data;
      else if (idx == CSR_PASS) board.pass_mode = data[0];
   endtask

   task automatic set_mode(logic [HINT_W-1:0] bits, logic pass);
      wait_idle();
      if ($urandom_range(1)) begin
         write_csr(CSR_PASS, {3'd0, pass});
         write_csr(CSR_HINT_BITS, bits);
      end else begin
         write_csr(CSR_HINT_BITS, bits);
         write_csr(CSR_PASS, {3'd0, pass});
      end
      csr_valid <= 1'b0;
      settings_done++;
   endtask

   // mostly a plausible decode order: hidden future frames loaded, then shown
   task automatic random_item();
      int r;
      logic present, shown, later;
      r = $urandom_range(99);
      if (r < 40) begin
         present = ($urandom_range(9) != 0);
         if ($urandom_range(9) < 6) begin
            shown = 1'b0;
            later = 1'b1;
         end else begin
            shown = 1'($urandom_range(1));
            later = 1'($urandom_range(1));
         end
         load(3'($urandom_range(7)), present, shown, later,
              hint_cursor + CNT_W'($urandom_range(1, 6)));
      end else if (r < 75) begin
         hint_cursor = hint_cursor + CNT_W'($urandom_range(1, 2));
         show(hint_cursor);
      end else if (r < 86) begin
         drain();
      end else begin
         send_item(2'($urandom_range(3)), 3'($urandom_range(7)), 1'($urandom_range(1)),
                   1'($urandom_range(1)), 1'($urandom_range(1)),
                   CNT_W'($urandom_range(255)));
      end
   endtask

   logic [HINT_W-1:0] phase_bits [PHASES] = '{4'd8, 4'd0, 4'd15, 4'd1, 4'd3, 4'd5, 4'd7};
   logic              phase_pass [PHASES] = '{1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b1};

   initial begin
      reset = 1'b1;
      start = 1'b0;
      req_opcode = OP_LOAD;
      req_slot_index = '0;
      req_slot_present = 1'b0;
      req_already_shown = 1'b0;
      req_can_show_later = 1'b0;
      req_frame_count = '0;
      csr_valid = 1'b0;
      csr_index = CSR_HINT_BITS;
      csr_wdata = '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed part under reset settings
      load(3'd0, 1'b1, 1'b0, 1'b1, 8'd2);
      load(3'd7, 1'b1, 1'b0, 1'b1, 8'd1);
      load(3'd3, 1'b1, 1'b1, 1'b1, 8'd5);       // shown at decode: never pending
      load(3'd4, 1'b1, 1'b0, 1'b0, 8'd3);       // not showable later
      load(3'd5, 1'b0, 1'b0, 1'b1, 8'd255);     // empty slot, count still stored
      show(8'd4);
      show(8'd3);                               // frame behind the last output
      drain();
      send_item(OP_UNUSED, 3'd7, 1'b1, 1'b1, 1'b1, 8'd255);
      load(3'd6, 1'b1, 1'b0, 1'b1, 8'd6);
      load(3'd2, 1'b1, 1'b0, 1'b1, 8'd5);
      show(8'd4);                               // successors follow the frame
      show(8'd4);                               // emitted slots stay pending
      load(3'd1, 1'b1, 1'b0, 1'b1, 8'd255);
      load(3'd5, 1'b1, 1'b0, 1'b1, 8'd0);
      drain();
      show(8'd0);
      show(8'd255);
      drain();

      for (int p = 0; p < PHASES; p++) begin
         set_mode(phase_bits[p], phase_pass[p]);
         no_idle = p[0];
         hint_cursor = CNT_W'($urandom_range(255));
         for (int i = 0; i < ITEMS_PER_PHASE; i++) random_item();
      end

      wait_idle();
      $display("Sent %0d loads, %0d shows, %0d drains, %0d unused opcodes; %0d results checked",
               op_seen[0], op_seen[1], op_seen[2], op_seen[3], board.checked);
      $display("Went through %0d register settings, hint widths 0 to 15, both output modes",
               settings_done);
      if (board.errors == 0)
         $display("frame_output_reorder test passed");
      else
         $display("frame_output_reorder test failed");
      $finish;
   end

endmodule

// ----- filelist.f -----
hdl/for_pkg.sv
hdl/for_cell.sv
hdl/frame_output_reorder.sv
tb/tb_frame_output_reorder.sv
